// ----- rtl/i2cbm_pkg.sv -----
// Shared types and constants for the I2C bit-level master core.
`timescale 1ns / 1ps

package i2cbm_pkg;

  // Command codes, also the sequencer's current-command state
  typedef enum logic [2:0] {
    CMD_IDLE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_WAITACK = 3'd4,
    CMD_READ    = 3'd5
  } cmd_e_t;

  // Configuration register indexes
  localparam logic REG_PHASE_TICKS = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd5;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  // Last bit position of a byte
  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_is_input;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_failed;
  } out_item_t;

endpackage

// ----- rtl/i2cbm_in_reg.sv -----
// Input register stage: holds one tick item until the sequencer takes it.
`timescale 1ns / 1ps

module i2cbm_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  i2cbm_pkg::in_item_t  in_item,
  input  logic                 take,
  output logic                 held_vld,
  output i2cbm_pkg::in_item_t  held_item
);
  import i2cbm_pkg::*;

  logic     vld_r;
  in_item_t item_r;

  // Stall only while a held item is not being consumed this cycle
  assign in_stall  = vld_r && !take;
  assign held_vld  = vld_r;
  assign held_item = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- rtl/i2cbm_seq.sv -----
// Bus sequencer: config registers, sequence state and one-tick step logic.
`timescale 1ns / 1ps

module i2cbm_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 fire,
  input  i2cbm_pkg::in_item_t  item,
  output i2cbm_pkg::out_item_t res
);
  import i2cbm_pkg::*;

  logic [7:0] phase_ticks_r;
  logic [7:0] ack_timeout_r;

  cmd_e_t     cmd_r, cmd_nxt, cmd_v;
  logic [2:0] phase_r, phase_nxt, ph_v;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] delay_r, delay_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic       ack_r, ack_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       dir_r, dir_nxt;
  logic       err_r, err_nxt;
  logic [7:0] rd_r, rd_nxt;
  logic       done;
  logic       run;
  logic       act_ok;
  logic [7:0] wait_val;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_PHASE_TICKS) phase_ticks_r <= cfg_wdata;
      if (cfg_index == REG_ACK_TIMEOUT) ack_timeout_r <= cfg_wdata;
    end
  end

  // Delay reload: zero phase_ticks behaves as one tick per phase
  assign wait_val = (phase_ticks_r == 8'd0) ? 8'd0 : phase_ticks_r - 8'd1;

  assign act_ok = (item.action >= CMD_START) && (item.action <= CMD_READ);

  // Sequence state registers, advanced once per consumed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= CMD_IDLE;
      phase_r <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      delay_r <= '0;
      poll_r  <= '0;
      ack_r   <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      dir_r   <= 1'b0;
      err_r   <= 1'b0;
      rd_r    <= '0;
    end else if (fire) begin
      cmd_r   <= cmd_nxt;
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      delay_r <= delay_nxt;
      poll_r  <= poll_nxt;
      ack_r   <= ack_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      dir_r   <= dir_nxt;
      err_r   <= err_nxt;
      rd_r    <= rd_nxt;
    end
  end

  // One tick of the sequencer
  always_comb begin
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    delay_nxt = delay_r;
    poll_nxt  = poll_r;
    ack_nxt   = ack_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    dir_nxt   = dir_r;
    err_nxt   = err_r;
    rd_nxt    = rd_r;
    done      = 1'b0;
    run       = 1'b0;
    cmd_v     = cmd_r;
    ph_v      = phase_r;

    if (cmd_r == CMD_IDLE) begin
      // Idle: a valid command starts at phase zero this tick
      if (act_ok) begin
        cmd_v     = cmd_e_t'(item.action);
        ph_v      = '0;
        delay_nxt = '0;
        run       = 1'b1;
        if (cmd_v == CMD_READ) ack_nxt = item.send_ack;
      end
    end else if (delay_r != 8'd0) begin
      delay_nxt = delay_r - 8'd1;
    end else begin
      run = 1'b1;
    end

    if (run) begin
      cmd_nxt = cmd_v;
      unique case (cmd_v)
        CMD_START: begin
          case (ph_v)
            3'd0: begin
              dir_nxt = 1'b0; sda_nxt = 1'b1; scl_nxt = 1'b1;
              delay_nxt = wait_val; phase_nxt = 3'd1;
            end
            3'd1: begin
              sda_nxt = 1'b0; delay_nxt = wait_val; phase_nxt = 3'd2;
            end
            default: begin
              scl_nxt = 1'b0; done = 1'b1;
            end
          endcase
        end
        CMD_STOP: begin
          case (ph_v)
            3'd0: begin
              dir_nxt = 1'b0; scl_nxt = 1'b0; sda_nxt = 1'b0;
              delay_nxt = wait_val; phase_nxt = 3'd1;
            end
            3'd1: begin
              scl_nxt = 1'b1; sda_nxt = 1'b1;
              delay_nxt = wait_val; phase_nxt = 3'd2;
            end
            default: done = 1'b1;
          endcase
        end
        CMD_WAITACK: begin
          case (ph_v)
            3'd0: begin
              dir_nxt = 1'b1; sda_nxt = 1'b1; poll_nxt = '0; err_nxt = 1'b0;
              delay_nxt = wait_val; phase_nxt = 3'd1;
            end
            3'd1: begin
              scl_nxt = 1'b1; delay_nxt = wait_val; phase_nxt = 3'd2;
            end
            default: begin
              if (!item.sda_in) begin
                scl_nxt = 1'b0; done = 1'b1;
              end else if (poll_r >= ack_timeout_r) begin
                // Timed out: flag it and fall straight into a stop
                err_nxt   = 1'b1;
                cmd_nxt   = CMD_STOP;
                dir_nxt   = 1'b0; scl_nxt = 1'b0; sda_nxt = 1'b0;
                delay_nxt = wait_val; phase_nxt = 3'd1;
              end else begin
                poll_nxt = poll_r + 8'd1;
              end
            end
          endcase
        end
        CMD_WRITE: begin
          case (ph_v)
            3'd0: begin
              // Setup and first data bit in the same tick
              dir_nxt   = 1'b0; scl_nxt = 1'b0; bit_nxt = '0;
              sda_nxt   = item.data_byte[7];
              shift_nxt = {item.data_byte[6:0], 1'b0};
              delay_nxt = wait_val; phase_nxt = 3'd2;
            end
            3'd1: begin
              sda_nxt   = shift_r[7];
              shift_nxt = {shift_r[6:0], 1'b0};
              delay_nxt = wait_val; phase_nxt = 3'd2;
            end
            3'd2: begin
              scl_nxt = 1'b1; delay_nxt = wait_val; phase_nxt = 3'd3;
            end
            3'd3: begin
              scl_nxt = 1'b0; delay_nxt = wait_val; phase_nxt = 3'd4;
            end
            default: begin
              if (bit_r >= LAST_BIT) begin
                done = 1'b1;
              end else begin
                bit_nxt   = bit_r + 3'd1;
                sda_nxt   = shift_r[7];
                shift_nxt = {shift_r[6:0], 1'b0};
                delay_nxt = wait_val; phase_nxt = 3'd2;
              end
            end
          endcase
        end
        CMD_READ: begin
          case (ph_v)
            3'd0: begin
              dir_nxt = 1'b1; bit_nxt = '0; shift_nxt = '0;
              scl_nxt = 1'b0; delay_nxt = wait_val; phase_nxt = 3'd2;
            end
            3'd1: begin
              scl_nxt = 1'b0; delay_nxt = wait_val; phase_nxt = 3'd2;
            end
            3'd2: begin
              // Sample the bus as SCL rises
              scl_nxt   = 1'b1;
              shift_nxt = {shift_r[6:0], item.sda_in};
              delay_nxt = wait_val; phase_nxt = 3'd3;
            end
            3'd3: begin
              if (bit_r >= LAST_BIT) begin
                rd_nxt  = shift_r;
                scl_nxt = 1'b0; dir_nxt = 1'b0; sda_nxt = !ack_r;
                delay_nxt = wait_val; phase_nxt = 3'd5;
              end else begin
                bit_nxt = bit_r + 3'd1;
                scl_nxt = 1'b0; delay_nxt = wait_val; phase_nxt = 3'd2;
              end
            end
            3'd4: begin
              scl_nxt = 1'b0; dir_nxt = 1'b0; sda_nxt = !ack_r;
              delay_nxt = wait_val; phase_nxt = 3'd5;
            end
            3'd5: begin
              scl_nxt = 1'b1; delay_nxt = wait_val; phase_nxt = 3'd6;
            end
            default: begin
              scl_nxt = 1'b0; done = 1'b1;
            end
          endcase
        end
        default: done = 1'b1;
      endcase
    end

    if (done) begin
      cmd_nxt   = CMD_IDLE;
      phase_nxt = '0;
      delay_nxt = '0;
    end
  end

  // Result item reflects the state after this tick
  always_comb begin
    res.scl_level    = scl_nxt;
    res.sda_level    = sda_nxt;
    res.sda_is_input = dir_nxt;
    res.busy_res     = (cmd_nxt != CMD_IDLE);
    res.done_res     = done;
    res.read_data    = rd_nxt;
    res.ack_failed   = err_nxt;
  end

`ifndef SYNTHESIS
  // A pending delay only exists inside a running sequence
  a_delay_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (delay_r != 8'd0) |-> (cmd_r != CMD_IDLE))
    else $error("delay pending while idle");

  // A delay tick counts down and leaves command and phase alone
  a_delay_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd_r != CMD_IDLE && delay_r != 8'd0) |=>
      (cmd_r == $past(cmd_r) && phase_r == $past(phase_r) &&
       delay_r == $past(delay_r) - 8'd1))
    else $error("delay tick changed sequence");

  // Idle with no command stays idle
  a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd_r == CMD_IDLE && !act_ok) |=> (cmd_r == CMD_IDLE))
    else $error("left idle without a command");

  // Phase never goes past the last read phase
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= 3'd6)
    else $error("phase out of range");
`endif

endmodule

// ----- rtl/i2c_bit_level_master_core.sv -----
// Top level of the I2C bit-level master core.
`timescale 1ns / 1ps
//
// Usage: each input item is one bus timing tick. It carries the sampled SDA
// level and, while the core is idle, a command (start, stop, write byte,
// wait ack, read byte). Commands arriving while busy are ignored.
// Every accepted tick produces exactly one result item with the SCL/SDA pin
// levels, SDA direction, busy/done flags, the last read byte and the
// acknowledge error, all as they stand after that tick.
// Channels use valid/stall; an item moves when valid is high and stall low.
// Configuration (phase_ticks at index 0, ack_timeout at index 1) is written
// through cfg_we/cfg_index/cfg_wdata while no tick is in flight.
// The accepted tick is held in the input register, then stepped and
// registered in the result register once that register has room.
// Throughput: one tick per cycle while out_stall is low; the combinational
// step logic feeding the result register sets that rate.
// When out_stall is high the result register holds and, once the input
// register is full, in_stall rises. Synchronous reset (rst_n low) returns
// the sequencer to idle with SCL and SDA released high and SDA as output,
// and restores phase_ticks 5 and ack_timeout 250.

module i2c_bit_level_master_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [7:0]            cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2cbm_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2cbm_pkg::out_item_t  out_item
);
  import i2cbm_pkg::*;

  logic      held_vld;
  in_item_t  held_item;
  logic      fire;
  out_item_t res;
  logic      out_vld_r;
  out_item_t out_item_r;

  // Step when an item is held and the result register has room
  assign fire = held_vld && (!out_vld_r || !out_stall);

  i2cbm_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .take      (fire),
    .held_vld  (held_vld),
    .held_item (held_item)
  );

  i2cbm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (held_item),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // A step always lands a result in the output register
  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("step without result");

  // Input side stalls only with a held item that cannot move
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (held_vld && out_vld_r && out_stall))
    else $error("spurious input stall");

  // A result waiting under stall is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |-> !fire)
    else $error("result overwritten under stall");
`endif

endmodule

// ----- sim/tb_i2c_bit_level_master_core.sv -----
// Testbench for the I2C bit-level master core: table-driven and random ticks checked by a predictor.
`timescale 1ns / 1ps

module tb_i2c_bit_level_master_core;
  import i2cbm_pkg::*;

  // Spare action codes, treated as tick only
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  // Pin levels that can be read off directly: {scl, sda, dir, busy, done, rd, err}
  localparam out_item_t IDLE_PINS     = {1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0};
  localparam out_item_t START_PINS    = {1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
  localparam out_item_t ACK_WAIT_PINS = {1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};

  localparam int IDLE_LIMIT = 2000;
  localparam int NUM_SETTINGS = 2;
  localparam int IN_BITS = $bits(in_item_t);

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic      cfg_index = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Register settings walked by the random part, zero included
  logic [7:0] len_plan [NUM_SETTINGS] = '{8'd0, 8'd2};
  logic [7:0] lim_plan [NUM_SETTINGS] = '{8'd0, 8'd3};
  int         tick_plan [NUM_SETTINGS] = '{1, 1};

  // Expected pin levels, oldest first
  out_item_t pending_levels [$];
  int        accepted_ticks = 0;
  int        checked_ticks = 0;
  int        bad_count = 0;
  int        burst_left = 0;
  int        idle_cycles = 0;
  logic [9:0] stall_cyc = '0;

  // Sequencer predictor state
  cmd_e_t     m_cmd = CMD_IDLE;
  logic [3:0] m_step = '0;
  logic [2:0] m_bit = '0;
  logic [7:0] m_shift = '0;
  logic [7:0] m_hold = '0;
  logic [7:0] m_polls = '0;
  logic       m_ack_out = 1'b0;
  logic       m_scl = 1'b1;
  logic       m_sda = 1'b1;
  logic       m_dir_in = 1'b0;
  logic       m_err = 1'b0;
  logic [7:0] m_rd_byte = '0;
  logic [7:0] m_phase_len = PHASE_TICKS_RST;
  logic [7:0] m_ack_limit = ACK_TIMEOUT_RST;

  i2c_bit_level_master_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Load a bus delay and move on to the given step
  function automatic void start_hold(logic [3:0] nxt);
    m_hold = (m_phase_len == 8'd0) ? 8'd0 : m_phase_len - 8'd1;
    m_step = nxt;
  endfunction

  // Run the sequence until a delay, a poll or its end; 1 when it ends
  function automatic logic seq_run(logic sda_b);
    for (int hop = 0; hop < 16; hop++) begin
      case (m_cmd)
        CMD_START: begin
          if (m_step == 4'd0) begin
            m_dir_in = 1'b0; m_sda = 1'b1; m_scl = 1'b1; start_hold(4'd1); return 1'b0;
          end
          if (m_step == 4'd1) begin
            m_sda = 1'b0; start_hold(4'd2); return 1'b0;
          end
          m_scl = 1'b0;
          return 1'b1;
        end
        CMD_STOP: begin
          if (m_step == 4'd0) begin
            m_dir_in = 1'b0; m_scl = 1'b0; m_sda = 1'b0; start_hold(4'd1); return 1'b0;
          end
          if (m_step == 4'd1) begin
            m_scl = 1'b1; m_sda = 1'b1; start_hold(4'd2); return 1'b0;
          end
          return 1'b1;
        end
        CMD_WAITACK: begin
          if (m_step == 4'd0) begin
            m_dir_in = 1'b1; m_sda = 1'b1; m_polls = '0; m_err = 1'b0;
            start_hold(4'd1);
            return 1'b0;
          end
          if (m_step == 4'd1) begin
            m_scl = 1'b1; start_hold(4'd2); return 1'b0;
          end
          if (!sda_b) begin
            m_scl = 1'b0;
            return 1'b1;
          end
          // out of polls: flag it and fall into a stop condition
          if (m_polls >= m_ack_limit) begin
            m_err = 1'b1;
            m_cmd = CMD_STOP;
            m_step = '0;
          end else begin
            m_polls++;
            return 1'b0;
          end
        end
        CMD_WRITE: begin
          if (m_step == 4'd0) begin
            m_dir_in = 1'b0; m_scl = 1'b0; m_bit = '0; m_step = 4'd1;
          end else if (m_step == 4'd1) begin
            m_sda = m_shift[7];
            m_shift = {m_shift[6:0], 1'b0};
            start_hold(4'd2);
            return 1'b0;
          end else if (m_step == 4'd2) begin
            m_scl = 1'b1; start_hold(4'd3); return 1'b0;
          end else if (m_step == 4'd3) begin
            m_scl = 1'b0; start_hold(4'd4); return 1'b0;
          end else if (m_bit >= LAST_BIT) begin
            return 1'b1;
          end else begin
            m_bit++;
            m_step = 4'd1;
          end
        end
        CMD_READ: begin
          if (m_step == 4'd0) begin
            m_dir_in = 1'b1; m_bit = '0; m_shift = '0; m_step = 4'd1;
          end else if (m_step == 4'd1) begin
            m_scl = 1'b0; start_hold(4'd2); return 1'b0;
          end else if (m_step == 4'd2) begin
            // data bit sampled as SCL rises
            m_scl = 1'b1;
            m_shift = {m_shift[6:0], sda_b};
            start_hold(4'd3);
            return 1'b0;
          end else if (m_step == 4'd3) begin
            if (m_bit >= LAST_BIT) begin
              m_rd_byte = m_shift;
              m_step = 4'd4;
            end else begin
              m_bit++;
              m_step = 4'd1;
            end
          end else if (m_step == 4'd4) begin
            m_scl = 1'b0; m_dir_in = 1'b0; m_sda = !m_ack_out;
            start_hold(4'd5);
            return 1'b0;
          end else if (m_step == 4'd5) begin
            m_scl = 1'b1; start_hold(4'd6); return 1'b0;
          end else begin
            m_scl = 1'b0;
            return 1'b1;
          end
        end
        default: return 1'b1;
      endcase
    end
    return 1'b1;
  endfunction

  // Advance the predictor by one tick and return the pin levels after it
  function automatic out_item_t bus_tick_levels(in_item_t it);
    logic      fin;
    out_item_t lv;
    fin = 1'b0;
    if (m_cmd == CMD_IDLE) begin
      if (it.action >= CMD_START && it.action <= CMD_READ) begin
        m_cmd = cmd_e_t'(it.action);
        m_step = '0;
        m_hold = '0;
        if (m_cmd == CMD_WRITE) m_shift = it.data_byte;
        if (m_cmd == CMD_READ) m_ack_out = it.send_ack;
        fin = seq_run(it.sda_in);
      end
    end else if (m_hold > 8'd0) begin
      m_hold--;
    end else begin
      fin = seq_run(it.sda_in);
    end
    if (fin) begin
      m_cmd = CMD_IDLE;
      m_step = '0;
      m_hold = '0;
    end
    lv.scl_level    = m_scl;
    lv.sda_level    = m_sda;
    lv.sda_is_input = m_dir_in;
    lv.busy_res     = (m_cmd != CMD_IDLE);
    lv.done_res     = fin;
    lv.read_data    = m_rd_byte;
    lv.ack_failed   = m_err;
    return lv;
  endfunction

  function automatic stim_row_t stim_row(logic [2:0] act, logic [7:0] data, logic sack,
                                         logic sda, logic typed, out_item_t want);
    stim_row_t r;
    r.item.action    = act;
    r.item.data_byte = data;
    r.item.send_ack  = sack;
    r.item.sda_in    = sda;
    r.typed          = typed;
    r.want           = want;
    return r;
  endfunction

  function automatic logic sda_draw(int low_pct);
    return ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
  endfunction

  // Mostly acknowledged, now and then a slave that never pulls SDA low
  function automatic int ack_low_pct();
    return ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(30, 100);
  endfunction

  // Offer one tick in bursts with random gaps; predict once it is taken
  task automatic push_tick(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t pred;
    int        gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = bus_tick_levels(it);
    pending_levels.push_back(typed ? want : pred);
    accepted_ticks++;
  endtask

  // Tick until the sequencer is idle; commands sent meanwhile are ignored
  task automatic settle(input int low_pct);
    in_item_t it;
    while (m_cmd != CMD_IDLE) begin
      it.action    = 3'($urandom_range(0, 7));
      it.data_byte = 8'($urandom);
      it.send_ack  = 1'($urandom);
      it.sda_in    = sda_draw(low_pct);
      push_tick(it, 1'b0, '0);
    end
  endtask

  task automatic run_cmd(input cmd_e_t act, input int low_pct);
    in_item_t it;
    settle(50);
    it.action    = act;
    it.data_byte = 8'($urandom);
    it.send_ack  = 1'($urandom);
    it.sda_in    = sda_draw(low_pct);
    push_tick(it, 1'b0, '0);
    settle(low_pct);
  endtask

  // One bus transaction: start, address, ack, a few data bytes, stop
  task automatic run_transfer();
    int nbytes;
    nbytes = $urandom_range(1, 3);
    run_cmd(CMD_START, 50);
    run_cmd(CMD_WRITE, 50);
    run_cmd(CMD_WAITACK, ack_low_pct());
    repeat (nbytes) begin
      if ($urandom_range(0, 1)) begin
        run_cmd(CMD_WRITE, 50);
        run_cmd(CMD_WAITACK, ack_low_pct());
      end else begin
        run_cmd(CMD_READ, 50);
      end
    end
    run_cmd(CMD_STOP, 50);
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_levels.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_PHASE_TICKS) m_phase_len = val;
    else m_ack_limit = val;
  endtask

  // Receiver stall: none, sparse random, periodic, heavy random
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 10'd1;
    case (stall_cyc[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= (stall_cyc[2:0] >= 3'd5);
      default: out_stall <= 1'($urandom_range(0, 1));
    endcase
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_levels.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) $display("result %0d with nothing expected: %h", checked_ticks,
                                      out_item);
      end else begin
        want = pending_levels.pop_front();
        if (out_item !== want) begin
          bad_count++;
          if (bad_count <= 10)
            $display({"result %0d: exp scl %b sda %b dir %b busy %b done %b rd %h err %b,",
                      " got scl %b sda %b dir %b busy %b done %b rd %h err %b"},
                     checked_ticks, want.scl_level, want.sda_level, want.sda_is_input,
                     want.busy_res, want.done_res, want.read_data, want.ack_failed,
                     out_item.scl_level, out_item.sda_level, out_item.sda_is_input,
                     out_item.busy_res, out_item.done_res, out_item.read_data,
                     out_item.ack_failed);
        end
      end
      checked_ticks++;
    end
  end

  // Watchdog on cycles where neither channel moves an item
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t r;
    in_item_t  it;
    int        ph;
    int        mark;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Start and stop at the reset phase length, then one-tick phases
    run_cmd(CMD_START, 50);
    run_cmd(CMD_STOP, 50);
    drain();
    write_reg(REG_PHASE_TICKS, 8'd1);

    // Directed part with the reset ack timeout: spare codes, every command, byte
    // extremes, ack success and timeout, ACK and NACK reads, commands out of order
    rows.push_back(stim_row(CMD_IDLE,    8'h00, 1'b0, 1'b1, 1'b1, IDLE_PINS));
    rows.push_back(stim_row(ACT_SPARE6,  8'hFF, 1'b1, 1'b0, 1'b1, IDLE_PINS));
    rows.push_back(stim_row(ACT_SPARE7,  8'h55, 1'b0, 1'b1, 1'b1, IDLE_PINS));
    rows.push_back(stim_row(CMD_START,   8'h00, 1'b0, 1'b1, 1'b1, START_PINS));
    rows.push_back(stim_row(CMD_WRITE,   8'h00, 1'b0, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(CMD_WAITACK, 8'h00, 1'b0, 1'b0, 1'b1, ACK_WAIT_PINS));
    rows.push_back(stim_row(CMD_WRITE,   8'hFF, 1'b1, 1'b1, 1'b0, '0));
    rows.push_back(stim_row(CMD_WAITACK, 8'hFF, 1'b0, 1'b1, 1'b0, '0));
    rows.push_back(stim_row(CMD_START,   8'hA5, 1'b0, 1'b1, 1'b0, '0));
    rows.push_back(stim_row(CMD_WRITE,   8'hA5, 1'b0, 1'b1, 1'b0, '0));
    rows.push_back(stim_row(CMD_WAITACK, 8'h00, 1'b0, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(CMD_READ,    8'h00, 1'b1, 1'b1, 1'b0, '0));
    rows.push_back(stim_row(CMD_READ,    8'hFF, 1'b0, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(CMD_STOP,    8'h00, 1'b0, 1'b1, 1'b0, '0));
    rows.push_back(stim_row(CMD_STOP,    8'h00, 1'b0, 1'b1, 1'b0, '0));
    rows.push_back(stim_row(CMD_WAITACK, 8'h00, 1'b0, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(CMD_READ,    8'h3C, 1'b1, 1'b1, 1'b0, '0));
    rows.push_back(stim_row(CMD_IDLE,    8'h00, 1'b1, 1'b0, 1'b0, '0));

    // Each row runs to completion; filler ticks keep the row's SDA level
    foreach (rows[i]) begin
      r = rows[i];
      push_tick(r.item, r.typed, r.want);
      while (m_cmd != CMD_IDLE) begin
        it.action    = 3'($urandom_range(0, 7));
        it.data_byte = 8'($urandom);
        it.send_ack  = 1'($urandom);
        it.sda_in    = r.item.sda_in;
        push_tick(it, 1'b0, '0);
      end
    end

    // Random part, one register setting after another
    for (ph = 0; ph < NUM_SETTINGS; ph++) begin
      settle(50);
      drain();
      write_reg(REG_PHASE_TICKS, len_plan[ph]);
      write_reg(REG_ACK_TIMEOUT, lim_plan[ph]);
      // a slave that never answers, under every setting
      run_cmd(CMD_START, 50);
      run_cmd(CMD_WAITACK, 0);
      mark = accepted_ticks;
      while (accepted_ticks - mark < tick_plan[ph]) begin
        if ($urandom_range(0, 9) < 8) begin
          run_transfer();
        end else begin
          repeat ($urandom_range(1, 6)) begin
            it = in_item_t'(IN_BITS'($urandom));
            push_tick(it, 1'b0, '0);
          end
          settle(50);
        end
        if ($urandom_range(0, 15) == 0) drain();
      end
    end

    settle(50);
    drain();
    repeat (8) @(posedge clk);
    if (bad_count == 0 && pending_levels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/i2cbm_pkg.sv
rtl/i2cbm_in_reg.sv
rtl/i2cbm_seq.sv
rtl/i2c_bit_level_master_core.sv
sim/tb_i2c_bit_level_master_core.sv
